// ----- hdl/stl_pkg.sv -----
// Package for the schema text lexer: sizes, token kind codes, lexer modes,
// token record types and character class / keyword helper functions.
// No dependencies; every other file of the block but stl_channels imports it.
package stl_pkg;

   localparam int POS_BITS      = 32;
   localparam int LEN_BITS      = 16;
   localparam int LINE_BITS     = 16;
   localparam int KEYWORD_CHARS = 9;

   localparam logic [LEN_BITS-1:0]  LEN_MAX  = {LEN_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

   // token kind codes
   localparam logic [4:0] KIND_UNKNOWN   = 5'd0;
   localparam logic [4:0] KIND_EOF       = 5'd1;
   localparam logic [4:0] KIND_IDENT     = 5'd2;
   localparam logic [4:0] KIND_STRUCT    = 5'd3;
   localparam logic [4:0] KIND_ENUM      = 5'd4;
   localparam logic [4:0] KIND_NAMESPACE = 5'd5;
   localparam logic [4:0] KIND_ROOT      = 5'd6;
   localparam logic [4:0] KIND_INCLUDE   = 5'd7;
   localparam logic [4:0] KIND_STRING    = 5'd8;
   localparam logic [4:0] KIND_UNTERM    = 5'd9;
   localparam logic [4:0] KIND_BOOL      = 5'd10;
   localparam logic [4:0] KIND_INT       = 5'd11;
   localparam logic [4:0] KIND_FLOAT     = 5'd12;
   localparam logic [4:0] KIND_LBRACE    = 5'd13;
   localparam logic [4:0] KIND_RBRACE    = 5'd14;
   localparam logic [4:0] KIND_LBRACKET  = 5'd15;
   localparam logic [4:0] KIND_RBRACKET  = 5'd16;
   localparam logic [4:0] KIND_SEMI      = 5'd17;
   localparam logic [4:0] KIND_COMMA     = 5'd18;
   localparam logic [4:0] KIND_EQUAL     = 5'd19;
   localparam logic [4:0] KIND_LESS      = 5'd20;
   localparam logic [4:0] KIND_GREATER   = 5'd21;

   // control characters
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_SLASH,
      MODE_LCOMMENT,
      MODE_BLOCK,
      MODE_BLOCK_STAR,
      MODE_IDENT,
      MODE_DIRECT,
      MODE_STRING,
      MODE_INT,
      MODE_FRAC
   } mode_type;

   typedef logic [KEYWORD_CHARS-1:0][7:0] kw_chars_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [31:0] token_offset;
      logic [15:0] token_size;
      logic [15:0] token_line;
      logic        run_last;
   } token_type;

   // results caused by one byte, first in order first
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } token_pair_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_sym(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "_";
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic [4:0] punct_kind(input logic [7:0] c);
      logic [4:0] k;
      case (c)
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         "[":     k = KIND_LBRACKET;
         "]":     k = KIND_RBRACKET;
         ";":     k = KIND_SEMI;
         ",":     k = KIND_COMMA;
         "=":     k = KIND_EQUAL;
         "<":     k = KIND_LESS;
         ">":     k = KIND_GREATER;
         default: k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   // lit holds the word right-aligned, first character in the highest used byte
   function automatic logic word_match(input kw_chars_type chars,
                                       input logic [LEN_BITS-1:0] len,
                                       input logic [8*KEYWORD_CHARS-1:0] lit,
                                       input int wlen);
      logic ok;
      ok = (len == LEN_BITS'(wlen));
      for (int j = 0; j < KEYWORD_CHARS; j++) begin
         if (j < wlen && chars[j] != lit[8*(wlen-1-j) +: 8]) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   function automatic logic [4:0] classify_ident(input kw_chars_type chars,
                                                 input logic [LEN_BITS-1:0] len);
      logic [4:0] k;
      k = KIND_IDENT;
      if (word_match(chars, len, "struct", 6)) k = KIND_STRUCT;
      else if (word_match(chars, len, "enum", 4)) k = KIND_ENUM;
      else if (word_match(chars, len, "namespace", 9)) k = KIND_NAMESPACE;
      else if (word_match(chars, len, "false", 5)) k = KIND_BOOL;
      else if (word_match(chars, len, "true", 4)) k = KIND_BOOL;
      return k;
   endfunction

   function automatic logic [4:0] classify_direct(input kw_chars_type chars,
                                                  input logic [LEN_BITS-1:0] len);
      logic [4:0] k;
      k = KIND_UNKNOWN;
      if (word_match(chars, len, "#root", 5)) k = KIND_ROOT;
      else if (word_match(chars, len, "#include", 8)) k = KIND_INCLUDE;
      return k;
   endfunction

   // store c at the current length if it still fits in the keyword window
   function automatic kw_chars_type append_kw(input kw_chars_type chars,
                                              input logic [LEN_BITS-1:0] len,
                                              input logic [7:0] c);
      kw_chars_type r;
      r = chars;
      for (int j = 0; j < KEYWORD_CHARS; j++) begin
         if ({{32{1'b0}}, len} == 64'(j)) r[j] = c;
      end
      return r;
   endfunction

   function automatic logic [LEN_BITS-1:0] len_inc(input logic [LEN_BITS-1:0] len);
      return (len != LEN_MAX) ? len + LEN_BITS'(1) : len;
   endfunction

endpackage

// ----- hdl/stl_channels.sv -----
// Channel interfaces of the schema text lexer: text byte in, token out.
// Plain valid/ready handshake; no dependencies.
interface stl_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

interface stl_token_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [31:0] token_offset;
   logic [15:0] token_size;
   logic [15:0] token_line;
   logic        run_last;

   modport source (output valid, output token_kind, output token_offset,
                   output token_size, output token_line, output run_last,
                   input ready);
   modport sink   (input valid, input token_kind, input token_offset,
                   input token_size, input token_line, input run_last,
                   output ready);
endinterface

// ----- hdl/stl_lexer_core.sv -----
// Lexer state registers and the per-byte mode update for the schema text lexer.
// Depends on stl_pkg.
module stl_lexer_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            text_byte,
   output stl_pkg::token_pair_type pair
);
   import stl_pkg::*;

   mode_type               mode_ff, mode_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [POS_BITS-1:0]    begin_ff, begin_in;
   logic [LEN_BITS-1:0]    len_ff, len_in;
   kw_chars_type           kw_ff, kw_in;

   logic       handle;
   logic       e1_valid, e2_valid;
   logic [4:0] e1_kind, e2_kind;
   logic [31:0] e1_off, e2_off;
   logic [15:0] e1_size, e2_size;
   logic       clear_all;
   logic [LINE_BITS-1:0] line_next;
   token_type  t1, t2;

   assign line_next = (line_ff != LINE_MAX) ? line_ff + LINE_BITS'(1) : line_ff;

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff + POS_BITS'(1);
      line_in   = line_ff;
      begin_in  = begin_ff;
      len_in    = len_ff;
      kw_in     = kw_ff;
      handle    = 1'b0;
      clear_all = 1'b0;
      e1_valid  = 1'b0;
      e1_kind   = KIND_UNKNOWN;
      e1_off    = 32'(begin_ff);
      e1_size   = 16'(len_ff);
      e2_valid  = 1'b0;
      e2_kind   = KIND_UNKNOWN;
      e2_off    = 32'(pos_ff);
      e2_size   = 16'd1;

      case (mode_ff)
         MODE_SLASH: begin
            if (text_byte == "/") begin
               mode_in = MODE_LCOMMENT;
            end else if (text_byte == "*") begin
               mode_in = MODE_BLOCK;
            end else begin
               e1_valid = 1'b1;
               e1_kind  = KIND_UNKNOWN;
               e1_size  = 16'd1;
               handle   = 1'b1;
            end
         end
         MODE_LCOMMENT: begin
            if (text_byte == CH_NUL || text_byte == CH_LF) handle = 1'b1;
         end
         MODE_BLOCK, MODE_BLOCK_STAR: begin
            if (text_byte == CH_NUL) begin
               handle = 1'b1;
            end else if (mode_ff == MODE_BLOCK_STAR && text_byte == "/") begin
               mode_in = MODE_IDLE;
            end else if (text_byte == "*") begin
               mode_in = MODE_BLOCK_STAR;
            end else begin
               mode_in = MODE_BLOCK;
               if (text_byte == CH_LF) line_in = line_next;
            end
         end
         MODE_IDENT, MODE_DIRECT: begin
            if (is_sym(text_byte)) begin
               kw_in  = append_kw(kw_ff, len_ff, text_byte);
               len_in = len_inc(len_ff);
            end else begin
               e1_valid = 1'b1;
               e1_kind  = (mode_ff == MODE_IDENT) ? classify_ident(kw_ff, len_ff)
                                                  : classify_direct(kw_ff, len_ff);
               handle   = 1'b1;
            end
         end
         MODE_STRING: begin
            if (text_byte == "\"") begin
               e1_valid = 1'b1;
               e1_kind  = KIND_STRING;
               mode_in  = MODE_IDLE;
            end else if (text_byte == CH_NUL || text_byte == CH_CR || text_byte == CH_LF) begin
               e1_valid = 1'b1;
               e1_kind  = KIND_UNTERM;
               e1_size  = 16'd0;
               handle   = 1'b1;
            end else begin
               len_in = len_inc(len_ff);
            end
         end
         MODE_INT: begin
            if (is_digit(text_byte)) begin
               kw_in  = append_kw(kw_ff, len_ff, text_byte);
               len_in = len_inc(len_ff);
            end else if (text_byte == "e" || text_byte == ".") begin
               kw_in   = append_kw(kw_ff, len_ff, text_byte);
               len_in  = len_inc(len_ff);
               mode_in = MODE_FRAC;
            end else begin
               e1_valid = 1'b1;
               e1_kind  = KIND_INT;
               handle   = 1'b1;
            end
         end
         MODE_FRAC: begin
            if (is_digit(text_byte)) begin
               kw_in  = append_kw(kw_ff, len_ff, text_byte);
               len_in = len_inc(len_ff);
            end else begin
               e1_valid = 1'b1;
               e1_kind  = KIND_FLOAT;
               handle   = 1'b1;
            end
         end
         default: begin
            handle = 1'b1;
         end
      endcase

      // treat the byte as the start of something new
      if (handle) begin
         mode_in = MODE_IDLE;
         if (text_byte == CH_NUL) begin
            e2_valid  = 1'b1;
            e2_kind   = KIND_EOF;
            clear_all = 1'b1;
         end else if (is_space(text_byte)) begin
            if (text_byte == CH_LF) line_in = line_next;
         end else if (text_byte == "/" || is_alpha(text_byte) || text_byte == "_" ||
                      text_byte == "#" || text_byte == "\"" || is_digit(text_byte) ||
                      text_byte == "-") begin
            kw_in    = '0;
            kw_in[0] = text_byte;
            begin_in = pos_ff;
            len_in   = LEN_BITS'(1);
            if (text_byte == "/") begin
               mode_in = MODE_SLASH;
            end else if (text_byte == "#") begin
               mode_in = MODE_DIRECT;
            end else if (text_byte == "\"") begin
               mode_in  = MODE_STRING;
               begin_in = pos_ff + POS_BITS'(1);
               len_in   = '0;
            end else if (is_digit(text_byte) || text_byte == "-") begin
               mode_in = MODE_INT;
            end else begin
               mode_in = MODE_IDENT;
            end
         end else begin
            e2_valid = 1'b1;
            e2_kind  = punct_kind(text_byte);
         end
      end

      if (clear_all) begin
         mode_in  = MODE_IDLE;
         pos_in   = '0;
         line_in  = LINE_BITS'(1);
         begin_in = '0;
         len_in   = '0;
         kw_in    = '0;
      end
   end

   always_comb begin
      t1 = '{token_kind: e1_kind, token_offset: e1_off, token_size: e1_size,
             token_line: 16'(line_ff), run_last: !e2_valid};
      t2 = '{token_kind: e2_kind, token_offset: e2_off, token_size: e2_size,
             token_line: 16'(line_ff), run_last: 1'b1};
      pair.count  = {1'b0, e1_valid} + {1'b0, e2_valid};
      pair.first  = e1_valid ? t1 : t2;
      pair.second = t2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         line_ff  <= LINE_BITS'(1);
         begin_ff <= '0;
         len_ff   <= '0;
         kw_ff    <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         line_ff  <= line_in;
         begin_ff <= begin_in;
         len_ff   <= len_in;
         kw_ff    <= kw_in;
      end
   end

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line count reached zero");

   a_nul_restarts: assert property (@(posedge clock) disable iff (reset)
      step && text_byte == CH_NUL |=> pos_ff == '0 && line_ff == LINE_BITS'(1) &&
                                      mode_ff == MODE_IDLE)
      else $error("end of text did not restart the lexer");

endmodule

// ----- hdl/stl_token_buffer.sv -----
// Two-entry token queue between the lexer core and the token channel.
// Depends on stl_pkg and stl_channels.
module stl_token_buffer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  stl_pkg::token_pair_type pair,
   output logic [1:0]              free_slots,
   stl_token_if.source             rsp_chan
);
   import stl_pkg::*;

   token_type  slot0_ff, slot0_in;
   token_type  slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;
   logic       pop;
   logic [1:0] keep;
   logic [1:0] added;

   assign pop        = (count_ff != 2'd0) && rsp_chan.ready;
   assign keep       = count_ff - {1'b0, pop};
   assign free_slots = 2'd2 - keep;
   assign added      = push ? pair.count : 2'd0;

   always_comb begin
      slot0_in = pop ? slot1_ff : slot0_ff;
      slot1_in = slot1_ff;
      case (keep)
         2'd0: begin
            slot0_in = pair.first;
            slot1_in = pair.second;
         end
         2'd1: begin
            slot1_in = pair.first;
         end
         default: begin
            slot1_in = slot1_ff;
         end
      endcase
      count_in = keep + added;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_chan.valid        = count_ff != 2'd0;
   assign rsp_chan.token_kind   = slot0_ff.token_kind;
   assign rsp_chan.token_offset = slot0_ff.token_offset;
   assign rsp_chan.token_size   = slot0_ff.token_size;
   assign rsp_chan.token_line   = slot0_ff.token_line;
   assign rsp_chan.run_last     = slot0_ff.run_last;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> {1'b0, keep} + {1'b0, pair.count} <= 3'd2)
      else $error("token queue overflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("token queue count out of range");

endmodule

// ----- hdl/schema_text_lexer_top.sv -----
// Top level of the schema text lexer: input byte register, lexer core and
// output token queue. Depends on stl_pkg, stl_channels, stl_lexer_core and
// stl_token_buffer.
//
// Usage:
//  - req_chan carries one text byte per transaction; byte 0 marks end of text.
//  - rsp_chan carries tokens: kind, start offset, size, line and run_last,
//    which is set on the last token caused by a byte. A byte causes zero,
//    one or two tokens; a NUL always causes an end-of-file token and
//    restarts the lexer (offset 0, line 1) for the next text.
//  - Path: an accepted byte waits in the input register; when it advances,
//    its tokens are registered in the queue, which drives rsp_chan.
//  - Throughput: one byte per cycle while the queue has room. The mode
//    update is a single pass of logic between the input register and the
//    two-entry token queue; a byte causing two tokens can hold the input, as
//    the queue drains one token per cycle while rsp_chan.ready is high.
//  - Stalls: while rsp_chan.ready is low the queue fills; the held byte waits
//    in the input register until the queue has room for all of its tokens,
//    and only then is req_chan.ready raised for the next one.
//  - Reset: synchronous; empties the input register and the queue and puts
//    the lexer between tokens at offset 0, line 1. req_chan.ready stays low
//    while reset is high.
module schema_text_lexer_top (
   input  logic         clock,
   input  logic         reset,
   stl_byte_if.sink     req_chan,
   stl_token_if.source  rsp_chan
);
   import stl_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff, in_byte_in;
   logic           advance;
   logic [1:0]     free_slots;
   token_pair_type pair;

   // hand the held byte to the core once the queue can take all its tokens
   assign advance       = in_valid_ff && (pair.count <= free_slots);
   assign req_chan.ready = !reset && (!in_valid_ff || advance);

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_byte_in  = req_chan.text_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   stl_lexer_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .text_byte (in_byte_ff),
      .pair      (pair)
   );

   stl_token_buffer u_buffer (
      .clock      (clock),
      .reset      (reset),
      .push       (advance),
      .pair       (pair),
      .free_slots (free_slots),
      .rsp_chan   (rsp_chan)
   );

   // a byte that cannot advance stays in the input register unchanged
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held text byte lost or changed");

endmodule

// ----- test/stl_token_checker.sv -----
// Token checker for the schema text lexer: watches both channels, predicts the
// tokens of every accepted text byte and compares them with the output channel.
// Depends on stl_pkg and stl_channels.
module stl_token_checker (
   input  logic        clock,
   input  logic        reset,
   stl_byte_if         byte_mon,
   stl_token_if        token_mon,
   output int unsigned fail_count,
   output int unsigned tokens_waiting,
   output int unsigned tokens_checked,
   output logic [21:0] kinds_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import stl_pkg::*;

   // predicted lexer state
   mode_type    lex_mode  = MODE_IDLE;
   logic [31:0] byte_pos  = '0;
   logic [15:0] line_no   = 16'd1;
   logic [31:0] tok_start = '0;
   logic [15:0] tok_len   = '0;
   logic [7:0]  tok_head [KEYWORD_CHARS];

   token_type   pending_tokens [$];
   int unsigned mismatches = 0;
   int unsigned checked    = 0;
   logic [21:0] seen_mask  = '0;

   task automatic lexer_clear();
      lex_mode  = MODE_IDLE;
      byte_pos  = '0;
      line_no   = 16'd1;
      tok_start = '0;
      tok_len   = '0;
      foreach (tok_head[j]) tok_head[j] = 8'h00;
   endtask

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_num(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [4:0] punct_code(input logic [7:0] c);
      case (c)
         "{":     return KIND_LBRACE;
         "}":     return KIND_RBRACE;
         "[":     return KIND_LBRACKET;
         "]":     return KIND_RBRACKET;
         ";":     return KIND_SEMI;
         ",":     return KIND_COMMA;
         "=":     return KIND_EQUAL;
         "<":     return KIND_LESS;
         ">":     return KIND_GREATER;
         default: return KIND_UNKNOWN;
      endcase
   endfunction

   function automatic logic head_is(input string w);
      if (tok_len != 16'(w.len())) return 1'b0;
      for (int j = 0; j < w.len(); j++) begin
         if (tok_head[j] != w[j]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [4:0] word_kind();
      if (head_is("struct")) return KIND_STRUCT;
      if (head_is("enum")) return KIND_ENUM;
      if (head_is("namespace")) return KIND_NAMESPACE;
      if (head_is("false") || head_is("true")) return KIND_BOOL;
      return KIND_IDENT;
   endfunction

   function automatic logic [4:0] directive_kind();
      if (head_is("#root")) return KIND_ROOT;
      if (head_is("#include")) return KIND_INCLUDE;
      return KIND_UNKNOWN;
   endfunction

   task automatic expect_token(input logic [4:0] kind, input logic [31:0] offset,
                               input logic [15:0] size);
      token_type t;
      t.token_kind   = kind;
      t.token_offset = offset;
      t.token_size   = size;
      t.token_line   = line_no;
      t.run_last     = 1'b0;
      pending_tokens.insert(pending_tokens.size(), t);
   endtask

   task automatic bump_line();
      if (line_no != LINE_MAX) line_no++;
   endtask

   task automatic open_token(input logic [31:0] start, input logic [7:0] c,
                             input mode_type m);
      lex_mode  = m;
      tok_start = start;
      tok_len   = 16'd1;
      foreach (tok_head[j]) tok_head[j] = 8'h00;
      tok_head[0] = c;
   endtask

   task automatic grow_token(input logic [7:0] c);
      if (tok_len < KEYWORD_CHARS) tok_head[tok_len] = c;
      if (tok_len != LEN_MAX) tok_len++;
   endtask

   // one text byte: close the open token if this byte ends it, then let the
   // byte start something new from the idle mode
   task automatic lex_byte(input logic [7:0] c);
      logic [31:0] here;
      logic        reenter;
      int          queued;
      token_type   t;
      here    = byte_pos;
      reenter = 1'b0;
      queued  = pending_tokens.size();
      case (lex_mode)
         MODE_SLASH: begin
            if (c == "/") lex_mode = MODE_LCOMMENT;
            else if (c == "*") lex_mode = MODE_BLOCK;
            else begin
               expect_token(KIND_UNKNOWN, tok_start, 16'd1);
               reenter = 1'b1;
            end
         end
         MODE_LCOMMENT: begin
            if (c == CH_NUL || c == CH_LF) reenter = 1'b1;
         end
         MODE_BLOCK, MODE_BLOCK_STAR: begin
            if (c == CH_NUL) reenter = 1'b1;
            else if (lex_mode == MODE_BLOCK_STAR && c == "/") lex_mode = MODE_IDLE;
            else if (c == "*") lex_mode = MODE_BLOCK_STAR;
            else begin
               lex_mode = MODE_BLOCK;
               if (c == CH_LF) bump_line();
            end
         end
         MODE_IDENT, MODE_DIRECT: begin
            if (is_letter(c) || is_num(c) || c == "_") grow_token(c);
            else begin
               expect_token((lex_mode == MODE_IDENT) ? word_kind() : directive_kind(),
                            tok_start, tok_len);
               reenter = 1'b1;
            end
         end
         MODE_STRING: begin
            if (c == "\"") begin
               expect_token(KIND_STRING, tok_start, tok_len);
               lex_mode = MODE_IDLE;
            end else if (c == CH_NUL || c == CH_CR || c == CH_LF) begin
               expect_token(KIND_UNTERM, tok_start, 16'd0);
               reenter = 1'b1;
            end else if (tok_len != LEN_MAX) begin
               tok_len++;
            end
         end
         MODE_INT: begin
            if (is_num(c)) grow_token(c);
            else if (c == "e" || c == ".") begin
               grow_token(c);
               lex_mode = MODE_FRAC;
            end else begin
               expect_token(KIND_INT, tok_start, tok_len);
               reenter = 1'b1;
            end
         end
         MODE_FRAC: begin
            if (is_num(c)) grow_token(c);
            else begin
               expect_token(KIND_FLOAT, tok_start, tok_len);
               reenter = 1'b1;
            end
         end
         default: reenter = 1'b1;
      endcase

      if (reenter && c == CH_NUL) begin
         // end of text: emit eof and restart at offset 0, line 1
         expect_token(KIND_EOF, here, 16'd1);
         lexer_clear();
      end else begin
         if (reenter) begin
            lex_mode = MODE_IDLE;
            if (c == " " || (c >= CH_TAB && c <= CH_CR)) begin
               if (c == CH_LF) bump_line();
            end else if (c == "/") open_token(here, c, MODE_SLASH);
            else if (is_letter(c) || c == "_") open_token(here, c, MODE_IDENT);
            else if (c == "#") open_token(here, c, MODE_DIRECT);
            else if (c == "\"") begin
               open_token(here + 32'd1, c, MODE_STRING);
               tok_len = '0;
            end else if (is_num(c) || c == "-") open_token(here, c, MODE_INT);
            else expect_token(punct_code(c), here, 16'd1);
         end
         byte_pos = here + 32'd1;
      end

      // flag the last token of this byte
      if (pending_tokens.size() > queued) begin
         t = pending_tokens.pop_back();
         t.run_last = 1'b1;
         pending_tokens.insert(pending_tokens.size(), t);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < 40)
         $display("[%0t] token %0d: %s is %0h, expected %0h", $realtime, checked, what,
                  got, want);
      mismatches++;
   endtask

   task automatic check_token();
      token_type want;
      if (token_mon.token_kind <= KIND_GREATER) seen_mask[token_mon.token_kind] = 1'b1;
      if (pending_tokens.size() == 0) begin
         report_mismatch("token with nothing pending, kind", 32'(token_mon.token_kind), '0);
      end else begin
         want = pending_tokens.pop_front();
         if (token_mon.token_kind != want.token_kind)
            report_mismatch("kind", 32'(token_mon.token_kind), 32'(want.token_kind));
         if (token_mon.token_offset != want.token_offset)
            report_mismatch("offset", token_mon.token_offset, want.token_offset);
         if (token_mon.token_size != want.token_size)
            report_mismatch("size", 32'(token_mon.token_size), 32'(want.token_size));
         if (token_mon.token_line != want.token_line)
            report_mismatch("line", 32'(token_mon.token_line), 32'(want.token_line));
         if (token_mon.run_last != want.run_last)
            report_mismatch("run_last", 32'(token_mon.run_last), 32'(want.run_last));
      end
      checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lexer_clear();
         pending_tokens.delete();
      end else begin
         if (byte_mon.valid && byte_mon.ready) lex_byte(byte_mon.text_byte);
         if (token_mon.valid && token_mon.ready) check_token();
      end
      fail_count     <= mismatches;
      tokens_waiting <= pending_tokens.size();
      tokens_checked <= checked;
      kinds_seen     <= seen_mask;
   end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the schema text lexer: clock, reset, text stimulus and
// output-side back-pressure, with stl_token_checker doing all the comparing.
// Depends on stl_pkg, stl_channels, schema_text_lexer_top and stl_token_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import stl_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned HOLD_AT      = 300;   // byte count that triggers the long hold

   logic clock;
   logic reset;

   stl_byte_if  req_chan ();
   stl_token_if rsp_chan ();

   int unsigned fail_count;
   int unsigned tokens_waiting;
   int unsigned tokens_checked;
   logic [21:0] kinds_seen;

   logic        idle_on       = 1'b1;
   logic        long_hold_req = 1'b0;
   int unsigned bytes_sent    = 0;
   int unsigned cycle_count   = 0;
   logic [7:0]  text_q [$];

   // character pools for the random text
   string      lead_set  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   string      sym_set   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string      punct_set = "{}[];,=<>";
   string      block_set = "ab*/\n x";
   string      kw_words [10] = '{"struct", "enum", "namespace", "false", "true",
                                 "structs", "enu", "namespacex", "True", "_true"};
   string      dir_words [5] = '{"#root", "#include", "#rooting", "#", "#inc"};
   logic [7:0] ws_set [6] = '{" ", CH_TAB, CH_LF, CH_CR, 8'h0B, 8'h0C};

   schema_text_lexer_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   stl_token_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .byte_mon       (req_chan),
      .token_mon      (rsp_chan),
      .fail_count     (fail_count),
      .tokens_waiting (tokens_waiting),
      .tokens_checked (tokens_checked),
      .kinds_seen     (kinds_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d tokens still expected", cycle_count,
                  tokens_waiting);
         $display("tb_top failed");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold on request so
   // the token queue fills and the lexer has to stall its input
   initial begin
      int unsigned hold_left;
      hold_left      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            hold_left--;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_chan.ready = 1'b0;
            hold_left      = $urandom_range(1, 13) - 1;
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   task automatic add_byte(input logic [7:0] c);
      text_q.insert(text_q.size(), c);
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) text_q.insert(text_q.size(), s[i]);
   endtask

   function automatic logic [7:0] pick_from(input string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   function automatic logic [7:0] any_digit();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   // one random lexeme, mostly well formed, some noise and broken pieces
   task automatic add_fragment();
      logic [7:0] c;
      case ($urandom_range(0, 19))
         0, 1, 2: begin
            add_byte(pick_from(lead_set));
            repeat ($urandom_range(0, 10)) add_byte(pick_from(sym_set));
         end
         3: add_str(kw_words[$urandom_range(0, 9)]);
         4: begin
            if ($urandom_range(0, 1)) add_str(dir_words[$urandom_range(0, 4)]);
            else begin
               add_byte("#");
               repeat ($urandom_range(0, 6)) add_byte(pick_from(sym_set));
            end
         end
         5, 6: begin
            if ($urandom_range(0, 2) == 0) add_byte("-");
            repeat ($urandom_range(0, 5)) add_byte(any_digit());
            if ($urandom_range(0, 1)) begin
               add_byte($urandom_range(0, 1) ? "." : "e");
               repeat ($urandom_range(0, 4)) add_byte(any_digit());
            end
         end
         7: begin
            add_byte("\"");
            repeat ($urandom_range(0, 8)) begin
               c = 8'($urandom_range(1, 255));
               if (c == "\"" || c == CH_CR || c == CH_LF) c = "s";
               add_byte(c);
            end
            // mostly closed, sometimes broken by a line end or end of text
            case ($urandom_range(0, 7))
               0:       add_byte(CH_LF);
               1:       add_byte(CH_CR);
               2:       add_byte(CH_NUL);
               default: add_byte("\"");
            endcase
         end
         8, 9, 10: add_byte(pick_from(punct_set));
         11: begin
            add_str("//");
            repeat ($urandom_range(0, 8)) add_byte(8'($urandom_range(1, 255)));
            add_byte(CH_LF);
         end
         12: begin
            add_str("/*");
            repeat ($urandom_range(0, 8)) add_byte(pick_from(block_set));
            if ($urandom_range(0, 7) == 0) add_byte(CH_NUL);
            else add_str("*/");
         end
         13: add_byte("/");
         14: add_byte(8'($urandom_range(0, 255)));
         15: add_byte(($urandom_range(0, 3) == 0) ? CH_NUL : 8'(" "));
         default: add_byte(ws_set[$urandom_range(0, 5)]);
      endcase
      case ($urandom_range(0, 2))
         0:       ;
         1:       add_byte(" ");
         default: add_byte(CH_LF);
      endcase
   endtask

   task automatic add_random(input int unsigned count);
      while (text_q.size() < count) add_fragment();
   endtask

   // feed the queued text, one transaction per byte, with random sender gaps
   task automatic send_text();
      logic [7:0] c;
      while (text_q.size() != 0) begin
         c = text_q.pop_front();
         if (idle_on && $urandom_range(0, 7) == 0) begin
            req_chan.valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         req_chan.valid     = 1'b1;
         req_chan.text_byte = c;
         do @(posedge clock); while (!req_chan.ready);
         @(negedge clock);
         bytes_sent++;
         if (bytes_sent == HOLD_AT) long_hold_req = 1'b1;
      end
      req_chan.valid = 1'b0;
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.text_byte = 8'h00;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: top-bit bytes, lone slash, unterminated string at a line end,
      // unknown directive, DEL, newline inside a block comment, lone minus,
      // float with exponent, and a block comment cut off by end of text
      add_byte(8'hFF);
      add_byte(8'h80);
      add_str("/x\"a");
      add_byte(CH_LF);
      add_str("#q{");
      add_byte(8'h7F);
      add_str("/*");
      add_byte(CH_LF);
      add_str("*/- 1e5;/*");
      add_byte(CH_NUL);
      send_text();

      // random text with idling on both sides and the long receiver hold
      add_random(500);
      send_text();

      // no idling from here on
      idle_on = 1'b0;

      add_random(300);
      add_byte(CH_NUL);
      send_text();

      // drain: wait for every predicted token, then watch for strays
      while (tokens_waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run summary: %0d text bytes in, %0d tokens compared, %0d of 22 token kinds seen",
               bytes_sent, tokens_checked, $countones(kinds_seen));
      if (fail_count == 0 && tokens_waiting == 0) begin
         $display("tb_top passed");
      end else begin
         $display("%0d mismatches, %0d tokens never arrived", fail_count, tokens_waiting);
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
